>>> sv/rboc_pkg.sv
// ----------------------------------------------------------------------------
// rboc_pkg
// Shared constants and types for the range byte occurrence counter.
// ----------------------------------------------------------------------------
package rboc_pkg;

  localparam int BLOCK_MAX      = 4096;
  localparam int CHECK_INTERVAL = 64;
  localparam int SYMBOLS        = 256;
  localparam int ADDR_W  = $clog2(BLOCK_MAX);          // byte position
  localparam int LEN_W   = ADDR_W + 1;                 // length / count
  localparam int OFS_W   = $clog2(CHECK_INTERVAL);     // offset inside interval
  localparam int SYM_W   = $clog2(SYMBOLS);
  localparam int CPS     = BLOCK_MAX / CHECK_INTERVAL; // stored checkpoints
  localparam int CPI_W   = $clog2(CPS);                // stored checkpoint index
  localparam int CP_W    = LEN_W - OFS_W;              // checkpoint number 0..CPS
  localparam int CK_DEPTH = CPS * SYMBOLS;
  localparam int CK_AW    = CPI_W + SYM_W;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APP_WR,
    ST_SNAP,
    ST_CK,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

>>> sv/rboc_if.sv
// ----------------------------------------------------------------------------
// rboc_if
// Request and result channels of the range byte occurrence counter.
// ----------------------------------------------------------------------------
interface rboc_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [7:0]                  data_byte;
  logic [rboc_pkg::ADDR_W-1:0] range_start;
  logic [rboc_pkg::ADDR_W-1:0] range_end;
  logic [7:0]                  query_byte;

  modport source (output valid, operation, data_byte, range_start, range_end,
                  query_byte, input ready);
  modport sink   (input valid, operation, data_byte, range_start, range_end,
                  query_byte, output ready);
endinterface

interface rboc_res_if;
  logic                       valid;
  logic                       ready;
  logic [rboc_pkg::LEN_W-1:0] occurrences;
  logic                       range_error;
  logic                       overflowed;

  modport source (output valid, occurrences, range_error, overflowed, input ready);
  modport sink   (input valid, occurrences, range_error, overflowed, output ready);
endinterface

>>> sv/range_byte_occurrence_count.sv
// ----------------------------------------------------------------------------
// range_byte_occurrence_count
// Appends bytes to a block, snapshots per-byte counts every interval, and
// answers inclusive range occurrence queries from snapshots plus short scans.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                               notes
//  request   in   operation, data_byte, range_start, range_end, query   1 item
//  result    out  occurrences, range_error, overflowed                  query only
//
//  Append: running-count read at accept, then write back; crossing an interval
//  boundary adds a sweep that copies all 256 running counts into checkpoints.
//  Query: a checkpoint read and a scan of the partial interval for end+1, then
//  the same for start, both scans on the single block memory read port; a bad
//  range goes straight to the result. Clear and unused code stay in idle. Reset clears control and count valid bits.
//  request.ready is high only when the sequencer is idle; a finished result
//  waits in the output register while appends and clears go on.
// ----------------------------------------------------------------------------
module range_byte_occurrence_count (
  input logic          clk,
  input logic          rst,
  rboc_req_if.sink     request,
  rboc_res_if.source   result
);

  rboc_pkg::state_t state, state_next;

  // Memories
  logic [7:0]                 blk_mem [rboc_pkg::BLOCK_MAX];
  logic [rboc_pkg::LEN_W-1:0] rc_mem  [rboc_pkg::SYMBOLS];
  logic [rboc_pkg::LEN_W-1:0] ck_mem  [rboc_pkg::CK_DEPTH];
  logic [7:0]                 blk_q;
  logic [rboc_pkg::LEN_W-1:0] rc_q, ck_q;
  logic [rboc_pkg::SYMBOLS-1:0] rc_vld;

  logic [rboc_pkg::LEN_W-1:0] length;
  logic                       overflow;
  logic [7:0]                 byte_reg;
  logic [rboc_pkg::CP_W-1:0]  snap_cp;
  logic [rboc_pkg::SYM_W:0]   snap_k;
  logic [7:0]                 snap_prev;
  logic                       snap_pend;

  logic [rboc_pkg::LEN_W-1:0] start_reg, end_p1;
  logic [7:0]                 sym;
  logic                       phase, err_reg;
  logic [rboc_pkg::ADDR_W-1:0] scan_addr;
  logic [rboc_pkg::OFS_W-1:0] scan_left;
  logic                       blk_pend, ck_pend, pend_neg;
  logic [rboc_pkg::LEN_W-1:0] acc;

  logic [rboc_pkg::LEN_W-1:0] pos, len_next, rc_inc;
  logic [rboc_pkg::CP_W-1:0]  pos_cp, snap_cp_m1, pos_cp_m1;
  logic                       accept, is_append, is_query, is_clear, bad_range;
  logic                       out_load;
  logic [7:0]                 rc_raddr;
  logic                       rc_ren;

  assign accept    = request.valid && request.ready;
  assign is_append = request.operation == rboc_pkg::OP_APPEND;
  assign is_query  = request.operation == rboc_pkg::OP_QUERY;
  assign is_clear  = request.operation == rboc_pkg::OP_CLEAR;
  assign bad_range = (request.range_start > request.range_end) ||
                     ({1'b0, request.range_end} >= length);
  assign pos       = phase ? start_reg : end_p1;
  assign pos_cp    = pos[rboc_pkg::LEN_W-1:rboc_pkg::OFS_W];
  assign pos_cp_m1 = pos_cp - rboc_pkg::CP_W'(1);
  assign snap_cp_m1 = snap_cp - rboc_pkg::CP_W'(1);
  assign len_next  = length + rboc_pkg::LEN_W'(1);
  assign rc_inc    = (rc_vld[byte_reg] ? rc_q : '0) + rboc_pkg::LEN_W'(1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rboc_pkg::ST_IDLE: begin
        if (accept && is_append && !length[rboc_pkg::ADDR_W])
          state_next = rboc_pkg::ST_APP_WR;
        else if (accept && is_query)
          state_next = bad_range ? rboc_pkg::ST_FIN : rboc_pkg::ST_CK;
      end
      rboc_pkg::ST_APP_WR: begin
        state_next = (len_next[rboc_pkg::OFS_W-1:0] == '0) ? rboc_pkg::ST_SNAP
                                                           : rboc_pkg::ST_IDLE;
      end
      rboc_pkg::ST_SNAP: begin
        if (snap_k[rboc_pkg::SYM_W]) state_next = rboc_pkg::ST_IDLE;
      end
      rboc_pkg::ST_CK: state_next = rboc_pkg::ST_SCAN;
      rboc_pkg::ST_SCAN: begin
        if (scan_left == '0) state_next = phase ? rboc_pkg::ST_FIN : rboc_pkg::ST_CK;
      end
      rboc_pkg::ST_FIN: begin
        if (out_load) state_next = rboc_pkg::ST_IDLE;
      end
      default: state_next = rboc_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    request.ready = state == rboc_pkg::ST_IDLE;
    out_load      = (state == rboc_pkg::ST_FIN) && (!result.valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rboc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Block store: write on append, read during scans
  always_ff @(posedge clk) begin
    if (accept && is_append && !length[rboc_pkg::ADDR_W])
      blk_mem[length[rboc_pkg::ADDR_W-1:0]] <= request.data_byte;
    if (state == rboc_pkg::ST_SCAN && scan_left != '0)
      blk_q <= blk_mem[scan_addr];
  end

  // Running counts: read for increment or snapshot, write back on append
  assign rc_raddr = (state == rboc_pkg::ST_SNAP) ? snap_k[rboc_pkg::SYM_W-1:0]
                                                 : request.data_byte;
  assign rc_ren   = (accept && is_append) ||
                    (state == rboc_pkg::ST_SNAP && !snap_k[rboc_pkg::SYM_W]);
  always_ff @(posedge clk) begin
    if (rc_ren) rc_q <= rc_mem[rc_raddr];
    if (state == rboc_pkg::ST_APP_WR) rc_mem[byte_reg] <= rc_inc;
  end

  // Checkpoints: filled by the snapshot sweep, read once per prefix
  always_ff @(posedge clk) begin
    if (snap_pend)
      ck_mem[{snap_cp_m1[rboc_pkg::CPI_W-1:0], snap_prev}] <=
        rc_vld[snap_prev] ? rc_q : '0;
    if (state == rboc_pkg::ST_CK && pos_cp != '0)
      ck_q <= ck_mem[{pos_cp_m1[rboc_pkg::CPI_W-1:0], sym}];
  end

  // Control: length, overflow, valid bits, snapshot sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      overflow  <= 1'b0;
      rc_vld    <= '0;
      snap_pend <= 1'b0;
    end else begin
      snap_pend <= (state == rboc_pkg::ST_SNAP) && !snap_k[rboc_pkg::SYM_W];
      if (accept && is_append && length[rboc_pkg::ADDR_W]) overflow <= 1'b1;
      if (accept && is_clear) begin
        length   <= '0;
        overflow <= 1'b0;
        rc_vld   <= '0;
      end
      if (state == rboc_pkg::ST_APP_WR) begin
        length           <= len_next;
        rc_vld[byte_reg] <= 1'b1;
      end
    end
  end

  // Payload registers of the sequencer
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_reg  <= request.data_byte;
      start_reg <= {1'b0, request.range_start};
      end_p1    <= {1'b0, request.range_end} + rboc_pkg::LEN_W'(1);
      sym       <= request.query_byte;
      err_reg   <= bad_range;
      phase     <= 1'b0;
    end
    if (state == rboc_pkg::ST_APP_WR) begin
      snap_cp <= len_next[rboc_pkg::LEN_W-1:rboc_pkg::OFS_W];
      snap_k  <= '0;
    end
    if (state == rboc_pkg::ST_SNAP) begin
      snap_k    <= snap_k + (rboc_pkg::SYM_W + 1)'(1);
      snap_prev <= snap_k[rboc_pkg::SYM_W-1:0];
    end
    if (state == rboc_pkg::ST_CK) begin
      scan_addr <= {pos[rboc_pkg::ADDR_W-1:rboc_pkg::OFS_W], {rboc_pkg::OFS_W{1'b0}}};
      scan_left <= pos[rboc_pkg::OFS_W-1:0];
    end
    if (state == rboc_pkg::ST_SCAN) begin
      if (scan_left != '0) begin
        scan_addr <= scan_addr + rboc_pkg::ADDR_W'(1);
        scan_left <= scan_left - rboc_pkg::OFS_W'(1);
      end else begin
        phase <= 1'b1;
      end
    end
    blk_pend <= (state == rboc_pkg::ST_SCAN) && (scan_left != '0);
    ck_pend  <= (state == rboc_pkg::ST_CK) && (pos_cp != '0);
    pend_neg <= phase;
  end

  // Accumulate prefix(end+1) minus prefix(start)
  always_ff @(posedge clk) begin
    if (accept) begin
      acc <= '0;
    end else if (ck_pend) begin
      acc <= pend_neg ? acc - ck_q : acc + ck_q;
    end else if (blk_pend && blk_q == sym) begin
      acc <= pend_neg ? acc - rboc_pkg::LEN_W'(1) : acc + rboc_pkg::LEN_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.occurrences <= err_reg ? '0 : acc;
      result.range_error <= err_reg;
      result.overflowed  <= overflow;
    end
  end

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= rboc_pkg::LEN_W'(rboc_pkg::BLOCK_MAX))
    else $error("block length beyond capacity");

  a_app_wr: assert property (@(posedge clk) disable iff (rst)
    accept && is_append && !length[rboc_pkg::ADDR_W] |=> state == rboc_pkg::ST_APP_WR)
    else $error("append did not enter write back");

  a_snap_cp: assert property (@(posedge clk) disable iff (rst)
    state == rboc_pkg::ST_SNAP |-> snap_cp != '0)
    else $error("snapshot into checkpoint zero");

  a_one_pend: assert property (@(posedge clk) disable iff (rst)
    !(ck_pend && blk_pend))
    else $error("two reads pending into accumulator");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives appends, range count queries, clears and unused codes into the range
// byte occurrence counter, predicts each query result from a plain byte store
// with a direct scan, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    rboc_pkg::op_t                 op;
    logic [7:0]                    data;
    logic [rboc_pkg::ADDR_W-1:0]   first;
    logic [rboc_pkg::ADDR_W-1:0]   last;
    logic [7:0]                    sym;
  } req_item_t;

  typedef struct packed {
    logic [rboc_pkg::LEN_W-1:0] occ;
    logic                       err;
    logic                       ovf;
  } count_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rboc_req_if request ();
  rboc_res_if result ();

  range_byte_occurrence_count dut (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [7:0]       model_bytes [rboc_pkg::BLOCK_MAX];
  int unsigned      model_len = 0;
  logic             model_ovf = 1'b0;
  count_result_t    expected_counts [$];

  // generator shadow of the block contents
  logic [7:0]       gen_bytes [rboc_pkg::BLOCK_MAX];
  int unsigned      gen_len = 0;

  req_item_t        pending_items [$];
  int unsigned      mismatches = 0;
  bit               steady = 1'b0;   // no idling on either side
  bit               hold_req = 1'b0;
  bit               hold_ack = 1'b0;
  int unsigned      hold_left = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // advance the predictor by one accepted item
  task automatic predict_item(input req_item_t it);
    count_result_t r;
    int unsigned   n;
    case (it.op)
      rboc_pkg::OP_APPEND: begin
        if (model_len >= rboc_pkg::BLOCK_MAX) begin
          model_ovf = 1'b1;
        end else begin
          model_bytes[model_len] = it.data;
          model_len++;
        end
      end
      rboc_pkg::OP_CLEAR: begin
        model_len = 0;
        model_ovf = 1'b0;
      end
      rboc_pkg::OP_QUERY: begin
        n = 0;
        r.err = (it.first > it.last) || (it.last >= model_len);
        if (!r.err) begin
          for (int unsigned i = it.first; i <= it.last; i++)
            if (model_bytes[i] == it.sym) n++;
        end
        r.occ = n[rboc_pkg::LEN_W-1:0];
        r.ovf = model_ovf;
        expected_counts.push_back(r);
      end
      default: ;
    endcase
  endtask

  // driver: hold the item until accepted, then load the next one
  always @(posedge clk) begin
    if (rst) begin
      request.valid       <= 1'b0;
      request.operation   <= rboc_pkg::OP_NONE;
      request.data_byte   <= '0;
      request.range_start <= '0;
      request.range_end   <= '0;
      request.query_byte  <= '0;
    end else begin
      if (request.valid && request.ready)
        predict_item(req_item_t'{rboc_pkg::op_t'(request.operation), request.data_byte,
                                 request.range_start, request.range_end,
                                 request.query_byte});
      if (!request.valid || request.ready) begin
        if (pending_items.size() > 0 && (steady || $urandom_range(0, 99) >= 7)) begin
          req_item_t it;
          it = pending_items.pop_front();
          request.valid       <= 1'b1;
          request.operation   <= it.op;
          request.data_byte   <= it.data;
          request.range_start <= it.first;
          request.range_end   <= it.last;
          request.query_byte  <= it.sym;
        end else begin
          request.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check accepted results, stall at random or for a long hold
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch("unexpected result", result.occurrences, -1);
        end else begin
          count_result_t e;
          e = expected_counts.pop_front();
          if (result.occurrences !== e.occ)
            report_mismatch("occurrences", result.occurrences, e.occ);
          if (result.range_error !== e.err)
            report_mismatch("range_error", result.range_error, e.err);
          if (result.overflowed !== e.ovf)
            report_mismatch("overflowed", result.overflowed, e.ovf);
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack  <= hold_req;
        hold_left <= 400;
        result.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= steady || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  task automatic push_item(input rboc_pkg::op_t op, input int d, input int s, input int e,
                           input int q);
    if (op == rboc_pkg::OP_APPEND) begin
      if (gen_len < rboc_pkg::BLOCK_MAX) begin
        gen_bytes[gen_len] = d[7:0];
        gen_len++;
      end
    end else if (op == rboc_pkg::OP_CLEAR) begin
      gen_len = 0;
    end
    pending_items.push_back(req_item_t'{op, d[7:0], s[rboc_pkg::ADDR_W-1:0],
                                        e[rboc_pkg::ADDR_W-1:0], q[7:0]});
  endtask

  // pick a byte that is likely present in the block
  function automatic int pick_sym();
    if (gen_len > 0 && $urandom_range(0, 99) < 60)
      return gen_bytes[$urandom_range(0, gen_len - 1)];
    return $urandom_range(0, 255);
  endfunction

  task automatic valid_query();
    int s, e;
    s = $urandom_range(0, gen_len - 1);
    e = ($urandom_range(0, 3) == 0) ? $urandom_range(s, gen_len - 1)
                                    : $urandom_range(s, (s + 130 < gen_len) ? s + 130
                                                                             : gen_len - 1);
    push_item(rboc_pkg::OP_QUERY, 0, s, e, pick_sym());
  endtask

  task automatic random_mix(input int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45 || gen_len == 0 && r < 85)
        push_item(rboc_pkg::OP_APPEND, ($urandom_range(0, 1) ? $urandom_range(0, 255)
                                                             : $urandom_range(0, 3)),
                  $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 255));
      else if (r < 85)
        valid_query();
      else if (r < 94)
        push_item(rboc_pkg::OP_QUERY, $urandom_range(0, 255), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 255));
      else if (r < 98)
        push_item(rboc_pkg::OP_NONE, $urandom_range(0, 255), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 255));
      else
        push_item(rboc_pkg::OP_CLEAR, $urandom_range(0, 255), 0, 0, 0);
    end
  endtask

  task automatic wait_drained();
    wait (pending_items.size() == 0);
    @(posedge clk);
    while (request.valid || expected_counts.size() > 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty block, unused code, short block, bad ranges, clear
    push_item(rboc_pkg::OP_QUERY, 0, 0, 0, 0);
    push_item(rboc_pkg::OP_NONE, 255, 4095, 4095, 255);
    push_item(rboc_pkg::OP_APPEND, 8'hff, 0, 0, 0);
    push_item(rboc_pkg::OP_APPEND, 8'h00, 0, 0, 0);
    push_item(rboc_pkg::OP_APPEND, 8'hff, 0, 0, 0);
    push_item(rboc_pkg::OP_QUERY, 0, 0, 2, 8'hff);
    push_item(rboc_pkg::OP_QUERY, 0, 1, 1, 8'h00);
    push_item(rboc_pkg::OP_QUERY, 0, 0, 0, 8'h00);
    push_item(rboc_pkg::OP_QUERY, 0, 2, 1, 8'hff);
    push_item(rboc_pkg::OP_QUERY, 0, 0, 3, 8'hff);
    push_item(rboc_pkg::OP_QUERY, 0, 4095, 4095, 8'hff);
    push_item(rboc_pkg::OP_CLEAR, 0, 0, 0, 0);
    push_item(rboc_pkg::OP_QUERY, 0, 0, 0, 8'hff);
    wait_drained();

    // fill across several checkpoints, then query around the boundaries
    for (int k = 0; k < 576; k++)
      push_item(rboc_pkg::OP_APPEND, $urandom_range(0, 1) ? $urandom_range(0, 255) : k % 5,
                0, 0, 0);
    push_item(rboc_pkg::OP_QUERY, 0, 0, 575, pick_sym());
    push_item(rboc_pkg::OP_APPEND, 8'haa, 0, 0, 0);
    push_item(rboc_pkg::OP_APPEND, 8'h55, 0, 0, 0);
    push_item(rboc_pkg::OP_QUERY, 0, 0, 577, 0);
    push_item(rboc_pkg::OP_QUERY, 0, 577, 577, gen_bytes[577]);
    push_item(rboc_pkg::OP_QUERY, 0, 63, 64, gen_bytes[64]);
    push_item(rboc_pkg::OP_QUERY, 0, 64, 127, pick_sym());
    push_item(rboc_pkg::OP_QUERY, 0, 4095, 0, 0);
    for (int k = 0; k < 40; k++) valid_query();
    wait_drained();

    // long receiver hold while queries keep coming
    push_item(rboc_pkg::OP_CLEAR, 0, 0, 0, 0);
    for (int k = 0; k < 100; k++)
      push_item(rboc_pkg::OP_APPEND, $urandom_range(0, 7), 0, 0, 0);
    wait_drained();
    hold_req = ~hold_req;
    for (int k = 0; k < 30; k++) valid_query();
    wait_drained();

    // random traffic, with one stretch free of idling
    random_mix(180);
    wait_drained();
    steady = 1'b1;
    random_mix(110);
    wait_drained();
    steady = 1'b0;
    random_mix(180);
    wait_drained();

    repeat (600) @(posedge clk);
    if (mismatches == 0 && expected_counts.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // watchdog
  initial begin
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
